// ----- hdl/mtp_pkg.sv -----
// mtp_pkg: types, constants and character decode for the mac address text parser
// no dependencies

package mtp_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned ADDR_BYTES = 6;
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned HASH_W     = 32;

    typedef logic [CHAR_W-1:0]             char_t;
    typedef logic [ADDR_BYTES-1:0][7:0]    addr_t;
    typedef logic [1:0]                    digit_cnt_t;
    typedef logic [2:0]                    sep_cnt_t;

    // separator characters
    localparam char_t CHAR_COLON  = 8'h3a;
    localparam char_t CHAR_HYPHEN = 8'h2d;

    // five separators make six groups
    localparam sep_cnt_t   SEP_MAX   = 3'd5;
    localparam digit_cnt_t DIGIT_MAX = 2'd2;

    // special address patterns
    localparam logic [ADDR_W-1:0] ADDR_BROADCAST = 48'hffff_ffff_ffff;
    localparam logic [15:0]       PFX_IPV6_MCAST = 16'h3333;
    localparam logic [23:0]       PFX_IPV4_MCAST = 24'h01005e;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_decode(input char_t c);
        hex_t h;
        h.ok     = 1'b0;
        h.nibble = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok     = 1'b1;
            h.nibble = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            // 'a'..'f' and 'A'..'F' share the low bits 1..6
            h.ok     = 1'b1;
            h.nibble = c[3:0] + 4'h9;
        end
        return h;
    endfunction

endpackage

// ----- hdl/mtp_char_if.sv -----
// mtp_char_if: valid/ready channel carrying one address text character
// depends on mtp_pkg

interface mtp_char_if;
    import mtp_pkg::*;

    logic  valid;
    logic  ready;
    char_t char_code;
    logic  is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ----- hdl/mtp_result_if.sv -----
// mtp_result_if: valid/ready channel carrying one parsed address result
// depends on mtp_pkg

interface mtp_result_if;
    import mtp_pkg::*;

    logic              valid;
    logic              ready;
    logic              valid_res;
    logic [ADDR_W-1:0] address;
    logic              mcast_bit;
    logic              special_match;
    logic [HASH_W-1:0] hash_value;

    modport source (output valid, output valid_res, output address, output mcast_bit,
                    output special_match, output hash_value, input ready);
    modport sink   (input valid, input valid_res, input address, input mcast_bit,
                    input special_match, input hash_value, output ready);
endinterface

// ----- hdl/mac_address_text_parser.sv -----
// mac_address_text_parser: streaming parser for textual 48-bit mac addresses
// depends on mtp_pkg, mtp_char_if, mtp_result_if
//
// channel    dir  word                                    handshake
// char_in    in   char_code, is_last                      valid/ready
// res_out    out  valid_res, address, mcast_bit,          valid/ready
//                 special_match, hash_value
// cfg        in   cfg_wr_data (separator select)          cfg_wr_en, no wait
//
// one character per cycle unless a last character waits for the slot; a word
// passes an input register and then the parse step into the result register
// the result register holds one word; characters that are not last keep
// flowing while a result waits, a last character waits for the slot
// rst_n clears the parse state, the separator select and both valid flags

module mac_address_text_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    mtp_char_if.sink             char_in,
    mtp_result_if.source         res_out
);
    import mtp_pkg::*;

    // separator select: 0 colon, 1 hyphen
    logic       sep_sel_reg;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    char_t      s1_char_reg;
    logic       s1_last_reg;

    // parse state
    addr_t      addr_reg, addr_next;
    digit_cnt_t digit_cnt_reg, digit_cnt_next;
    sep_cnt_t   sep_cnt_reg, sep_cnt_next;
    logic       err_reg, err_next;

    // result register
    logic              res_valid_reg, res_valid_next;
    logic              res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              res_mcast_reg, res_mcast_next;
    logic              res_special_reg, res_special_next;

    logic       s1_take;
    logic       s2_go;
    hex_t       hex;
    logic       is_sep;
    logic [2:0] byte_sel;
    logic [ADDR_W-1:0] addr_flat;
    logic       done_ok;

    // a last character may only move on when the result slot is free
    assign s2_go   = s1_valid_reg && (!s1_last_reg || !res_valid_reg || res_out.ready);
    assign char_in.ready = !s1_valid_reg || s2_go;
    assign s1_take = char_in.valid && char_in.ready;

    assign hex      = hex_decode(s1_char_reg);
    assign is_sep   = s1_char_reg == (sep_sel_reg ? CHAR_HYPHEN : CHAR_COLON);
    // group n lands in byte 5-n, the first group on top
    assign byte_sel = SEP_MAX - sep_cnt_reg;

    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        addr_next        = addr_reg;
        digit_cnt_next   = digit_cnt_reg;
        sep_cnt_next     = sep_cnt_reg;
        err_next         = err_reg;
        res_valid_next   = res_valid_reg;
        res_ok_next      = res_ok_reg;
        res_addr_next    = res_addr_reg;
        res_mcast_next   = res_mcast_reg;
        res_special_next = res_special_reg;
        addr_flat        = '0;
        done_ok          = 1'b0;

        if (s1_take)
            s1_valid_next = 1'b1;
        else if (s2_go)
            s1_valid_next = 1'b0;

        if (res_out.ready)
            res_valid_next = 1'b0;

        if (s2_go && !err_reg)
        begin
            if (hex.ok && digit_cnt_reg < DIGIT_MAX)
            begin
                for (int b = 0; b < ADDR_BYTES; b++)
                begin
                    if (byte_sel == 3'(b))
                        addr_next[b] = {addr_reg[b][3:0], hex.nibble};
                end
                digit_cnt_next = digit_cnt_reg + 2'd1;
            end
            else if (is_sep && digit_cnt_reg != 2'd0 && sep_cnt_reg != SEP_MAX)
            begin
                sep_cnt_next   = sep_cnt_reg + 3'd1;
                digit_cnt_next = '0;
            end
            else
            begin
                err_next = 1'b1;
            end
        end

        if (s2_go && s1_last_reg)
        begin
            // result is formed from the state after the last character
            done_ok          = !err_next && sep_cnt_next == SEP_MAX;
            addr_flat        = done_ok ? addr_next : '0;
            res_valid_next   = 1'b1;
            res_ok_next      = done_ok;
            res_addr_next    = addr_flat;
            res_mcast_next   = addr_flat[40];
            res_special_next = done_ok && (addr_flat == ADDR_BROADCAST
                                           || addr_flat[47:32] == PFX_IPV6_MCAST
                                           || addr_flat[47:24] == PFX_IPV4_MCAST);
            addr_next        = '0;
            digit_cnt_next   = '0;
            sep_cnt_next     = '0;
            err_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_sel_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            addr_reg      <= '0;
            digit_cnt_reg <= '0;
            sep_cnt_reg   <= '0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                sep_sel_reg <= cfg_wr_data;
            s1_valid_reg  <= s1_valid_next;
            addr_reg      <= addr_next;
            digit_cnt_reg <= digit_cnt_next;
            sep_cnt_reg   <= sep_cnt_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_char_reg <= char_in.char_code;
            s1_last_reg <= char_in.is_last;
        end
        res_ok_reg      <= res_ok_next;
        res_addr_reg    <= res_addr_next;
        res_mcast_reg   <= res_mcast_next;
        res_special_reg <= res_special_next;
    end

    assign res_out.valid         = res_valid_reg;
    assign res_out.valid_res     = res_ok_reg;
    assign res_out.address       = res_addr_reg;
    assign res_out.mcast_bit     = res_mcast_reg;
    assign res_out.special_match = res_special_reg;
    assign res_out.hash_value    = res_addr_reg[HASH_W-1:0];

    // group and digit counters stay in range
    a_sep_range: assert property (@(posedge clk) disable iff (!rst_n)
        sep_cnt_reg <= SEP_MAX)
        else $error("separator count out of range");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_cnt_reg <= DIGIT_MAX)
        else $error("digit count out of range");

    // a failed parse carries an all-zero word
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ok_reg) |-> (res_addr_reg == '0 && !res_special_reg))
        else $error("invalid result with nonzero fields");

    // state is cleared after the last character of a string
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && s1_last_reg) |=> (sep_cnt_reg == '0 && digit_cnt_reg == '0 && !err_reg))
        else $error("parse state not cleared after last character");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_out.ready) |=> (res_valid_reg && $stable(res_addr_reg)))
        else $error("pending result lost");

endmodule
